>>> hw/rtl/modexp_pkg.sv
package modexp_pkg;

    localparam int EXP_BITS = 32;
    localparam int MOD_BITS = 31;

    localparam int BASE_W = 31;
    localparam int EXPO_W = 32;
    localparam int RES_W  = 31;

    localparam int MCNT_W = (MOD_BITS > 1) ? $clog2(MOD_BITS) : 1;
    localparam int ECNT_W = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;

    localparam logic [MOD_BITS-1:0] MODULUS_RESET = MOD_BITS'(1000000007);

    typedef struct packed {
        logic load;
        logic prep_mul;
        logic prep_sqr;
        logic step;
        logic wr_pw;
        logic wr_acc;
        logic shift_exp;
        logic emit;
    } ctl_cmd_t;

    typedef struct packed {
        logic exp_lsb;
        logic mul_last;
        logic exp_last;
    } dp_status_t;

endpackage

>>> hw/rtl/modexp_dp.sv
module modexp_dp
    import modexp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                modulus_wr_en,
    input  logic [RES_W-1:0]    modulus,
    input  logic [BASE_W-1:0]   base,
    input  logic [EXPO_W-1:0]   exponent,
    input  ctl_cmd_t            cmd,
    output dp_status_t          status,
    output logic                done,
    output logic [RES_W-1:0]    residue
);

    logic [MOD_BITS-1:0] mod_reg;
    logic [MOD_BITS-1:0] pw_reg, pw_next;
    logic [MOD_BITS-1:0] acc_reg, acc_next;
    logic [MOD_BITS-1:0] prod_reg, prod_next;
    logic [MOD_BITS-1:0] mr_reg, mr_next;
    logic [MOD_BITS-1:0] ad_reg, ad_next;
    logic [EXP_BITS-1:0] exp_reg, exp_next;
    logic [MCNT_W-1:0]   mcnt_reg, mcnt_next;
    logic [ECNT_W-1:0]   ecnt_reg, ecnt_next;
    logic [RES_W-1:0]    res_reg, res_next;
    logic                done_reg;

    logic [MOD_BITS+1:0] sum;
    logic [MOD_BITS+1:0] mod1;
    logic [MOD_BITS+1:0] mod2;
    logic [MOD_BITS+1:0] red_wide;
    logic [MOD_BITS-1:0] red;
    logic                mod_zero;
    logic                mod_one;

    assign mod_zero = (mod_reg == '0);
    assign mod_one  = (mod_reg == MOD_BITS'(1));

    assign sum  = {1'b0, prod_reg, 1'b0}
                + (mr_reg[MOD_BITS-1] ? {2'b00, ad_reg} : '0);
    assign mod1 = {2'b00, mod_reg};
    assign mod2 = {1'b0, mod_reg, 1'b0};

    always_comb
    begin
        if (sum >= mod2)
        begin
            red_wide = sum - mod2;
        end
        else if (sum >= mod1)
        begin
            red_wide = sum - mod1;
        end
        else
        begin
            red_wide = sum;
        end
    end

    assign red = red_wide[MOD_BITS-1:0];

    always_comb
    begin
        pw_next   = pw_reg;
        acc_next  = acc_reg;
        prod_next = prod_reg;
        mr_next   = mr_reg;
        ad_next   = ad_reg;
        exp_next  = exp_reg;
        mcnt_next = mcnt_reg;
        ecnt_next = ecnt_reg;
        res_next  = res_reg;

        if (cmd.load)
        begin
            exp_next  = exponent[EXP_BITS-1:0];
            mr_next   = MOD_BITS'(base);
            ad_next   = MOD_BITS'(1);
            prod_next = '0;
            mcnt_next = '0;
            ecnt_next = '0;
            acc_next  = mod_one ? '0 : MOD_BITS'(1);
        end
        if (cmd.prep_mul)
        begin
            mr_next   = acc_reg;
            ad_next   = pw_reg;
            prod_next = '0;
            mcnt_next = '0;
        end
        if (cmd.prep_sqr)
        begin
            mr_next   = pw_reg;
            ad_next   = pw_reg;
            prod_next = '0;
            mcnt_next = '0;
        end
        if (cmd.step)
        begin
            prod_next = red;
            mr_next   = {mr_reg[MOD_BITS-2:0], 1'b0};
            mcnt_next = mcnt_reg + MCNT_W'(1);
        end
        if (cmd.wr_pw)
        begin
            pw_next = prod_reg;
        end
        if (cmd.wr_acc)
        begin
            acc_next = prod_reg;
        end
        if (cmd.shift_exp)
        begin
            exp_next  = exp_reg >> 1;
            ecnt_next = ecnt_reg + ECNT_W'(1);
        end
        if (cmd.emit)
        begin
            res_next = mod_zero ? '0 : RES_W'(acc_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg  <= MODULUS_RESET;
            done_reg <= 1'b0;
        end
        else
        begin
            if (modulus_wr_en)
            begin
                mod_reg <= modulus[MOD_BITS-1:0];
            end
            done_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        pw_reg   <= pw_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        mr_reg   <= mr_next;
        ad_reg   <= ad_next;
        exp_reg  <= exp_next;
        mcnt_reg <= mcnt_next;
        ecnt_reg <= ecnt_next;
        res_reg  <= res_next;
    end

    assign status.exp_lsb  = exp_reg[0];
    assign status.mul_last = (mcnt_reg == MCNT_W'(MOD_BITS - 1));
    assign status.exp_last = (ecnt_reg == ECNT_W'(EXP_BITS - 1));

    assign done    = done_reg;
    assign residue = res_reg;

endmodule

>>> hw/rtl/modexp_ctrl.sv
module modexp_ctrl
    import modexp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t status,
    output ctl_cmd_t   cmd,
    output logic       busy
);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_RED  = 9'b000000010,
        S_WPW  = 9'b000000100,
        S_BIT  = 9'b000001000,
        S_MUL  = 9'b000010000,
        S_WAC  = 9'b000100000,
        S_SQR  = 9'b001000000,
        S_WSQ  = 9'b010000000,
        S_FIN  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_RED;
                end
            end
            S_RED:
            begin
                cmd.step = 1'b1;
                if (status.mul_last)
                begin
                    state_next = S_WPW;
                end
            end
            S_WPW:
            begin
                cmd.wr_pw  = 1'b1;
                state_next = S_BIT;
            end
            S_BIT:
            begin
                if (status.exp_lsb)
                begin
                    cmd.prep_mul = 1'b1;
                    state_next   = S_MUL;
                end
                else
                begin
                    cmd.prep_sqr = 1'b1;
                    state_next   = S_SQR;
                end
            end
            S_MUL:
            begin
                cmd.step = 1'b1;
                if (status.mul_last)
                begin
                    state_next = S_WAC;
                end
            end
            S_WAC:
            begin
                cmd.wr_acc   = 1'b1;
                cmd.prep_sqr = 1'b1;
                state_next   = S_SQR;
            end
            S_SQR:
            begin
                cmd.step = 1'b1;
                if (status.mul_last)
                begin
                    state_next = S_WSQ;
                end
            end
            S_WSQ:
            begin
                cmd.wr_pw     = 1'b1;
                cmd.shift_exp = 1'b1;
                state_next    = status.exp_last ? S_FIN : S_BIT;
            end
            S_FIN:
            begin
                cmd.emit   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

>>> hw/rtl/modular_exponentiation_core.sv
// Channel   Handshake              Beat
// input     start, busy            base, exponent (taken when start && !busy)
// result    done                   residue (valid for the single cycle of done)
// config    modulus_wr_en          modulus (written on any edge with modulus_wr_en)
//
// The run time of a beat is set by the single bit-serial modular multiplier,
// one operand bit per cycle, shared by base reduction, multiply and square;
// a multiply is done for each set exponent bit, a square for every bit.
// done rises in the cycle after the emit state, the cycle busy falls.
// Reset clears the controller and loads modulus with 1000000007.
// The receiver cannot stall; the residue is held until the next result is emitted.
module modular_exponentiation_core
    import modexp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [BASE_W-1:0]   base,
    input  logic [EXPO_W-1:0]   exponent,
    output logic                done,
    output logic [RES_W-1:0]    residue,
    input  logic                modulus_wr_en,
    input  logic [RES_W-1:0]    modulus
);

    ctl_cmd_t   cmd;
    dp_status_t status;

    modexp_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    modexp_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .modulus_wr_en (modulus_wr_en),
        .modulus       (modulus),
        .base          (base),
        .exponent      (exponent),
        .cmd           (cmd),
        .status        (status),
        .done          (done),
        .residue       (residue)
    );

endmodule

>>> hw/rtl/modexp_chk.sv
module modexp_chk
    import modexp_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input logic [RES_W-1:0] residue
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted beat");

    a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("done outside end of work");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result repeated");

    a_busy_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("work ended without result");

    a_residue_known: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$isunknown(residue))
        else $error("unknown residue on done");

endmodule

bind modular_exponentiation_core modexp_chk u_modexp_chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .done    (done),
    .residue (residue)
);
